@@ src/interrupt_pending_priority_table_macros.svh @@
// assertion helpers shared by the ippt modules
// each expects clk and rst_n in scope
`ifndef INTERRUPT_PENDING_PRIORITY_TABLE_MACROS_SVH
`define INTERRUPT_PENDING_PRIORITY_TABLE_MACROS_SVH

// same-cycle implication
`define IPPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ippt_pkg.sv @@
`default_nettype none
package ippt_pkg;

  localparam int EVENT_W = 12;
  localparam int LEVEL_W = 4;

  localparam logic [EVENT_W-1:0] EXT_EVENT_LOW  = 12'h600;
  localparam logic [EVENT_W-1:0] EXT_EVENT_HIGH = 12'h700;

  typedef enum logic [1:0] {
    OP_ASSERT = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_ACCEPT = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    logic load;   // capture input word, restart scan
    logic step;   // visit one slot
    logic apply;  // commit table update and load result
  } ippt_cmd_t;

  typedef struct packed {
    logic scan_last;
  } ippt_sts_t;

endpackage
`default_nettype wire

@@ src/ippt_if.sv @@
`default_nettype none
interface ippt_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic [ippt_pkg::EVENT_W-1:0] event_code;
  logic [ippt_pkg::LEVEL_W-1:0] level;
  logic [ippt_pkg::LEVEL_W-1:0] interrupt_mask;
  logic                        block_flag;

  modport source (output valid, opcode, event_code, level, interrupt_mask, block_flag,
                  input ready);
  modport sink (input valid, opcode, event_code, level, interrupt_mask, block_flag,
                output ready);
endinterface

interface ippt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [ippt_pkg::EVENT_W-1:0] accepted_event;
  logic [ippt_pkg::LEVEL_W-1:0] accepted_level;
  logic                        dropped;
  logic                        any_pending;

  modport source (output valid, accepted, accepted_event, accepted_level, dropped,
                  any_pending, input ready);
  modport sink (input valid, accepted, accepted_event, accepted_level, dropped,
                any_pending, output ready);
endinterface
`default_nettype wire

@@ src/ippt_ctrl.sv @@
`default_nettype none
`include "interrupt_pending_priority_table_macros.svh"
module ippt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire ippt_pkg::ippt_sts_t sts,
  output ippt_pkg::ippt_cmd_t      cmd
);
  import ippt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.apply = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.apply) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `IPPT_ASSERT_IMP(a_apply_free, cmd.apply, out_free, "result overwritten before taken")
  `IPPT_ASSERT_IMP(a_valid_from_apply, $rose(out_valid_r), $past(state_r == ST_APPLY),
                   "result raised outside apply")

endmodule
`default_nettype wire

@@ src/ippt_datapath.sv @@
`default_nettype none
`include "interrupt_pending_priority_table_macros.svh"
module ippt_datapath #(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ippt_pkg::ippt_cmd_t           cmd,
  output ippt_pkg::ippt_sts_t                sts,
  input  wire logic [1:0]                    opcode,
  input  wire logic [ippt_pkg::EVENT_W-1:0]  event_code,
  input  wire logic [ippt_pkg::LEVEL_W-1:0]  level,
  input  wire logic [ippt_pkg::LEVEL_W-1:0]  interrupt_mask,
  input  wire logic                          block_flag,
  output logic                               accepted,
  output logic [ippt_pkg::EVENT_W-1:0]       accepted_event,
  output logic [ippt_pkg::LEVEL_W-1:0]       accepted_level,
  output logic                               dropped,
  output logic                               any_pending
);
  import ippt_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);

  // slot table
  logic [SLOT_COUNT-1:0] slot_pending_r, slot_pending_nxt;
  logic [EVENT_W-1:0]    slot_event_r [SLOT_COUNT];
  logic [EVENT_W-1:0]    slot_event_nxt [SLOT_COUNT];
  logic [LEVEL_W-1:0]    slot_level_r [SLOT_COUNT];
  logic [LEVEL_W-1:0]    slot_level_nxt [SLOT_COUNT];

  // captured word
  op_t                op_r;
  logic [EVENT_W-1:0] code_r;
  logic [LEVEL_W-1:0] lvl_r;
  logic [LEVEL_W-1:0] mask_r;
  logic               blk_r;

  // scan state
  logic [IDX_W-1:0]   idx_r;
  logic               hit_r, free_r, best_r;
  logic [IDX_W-1:0]   hit_idx_r, free_idx_r, best_idx_r;
  logic [LEVEL_W-1:0] best_lvl_r;
  logic [EVENT_W-1:0] best_event_r;

  // result register
  logic               accepted_r;
  logic [EVENT_W-1:0] accepted_event_r;
  logic [LEVEL_W-1:0] accepted_level_r;
  logic               dropped_r;
  logic               any_pending_r;

  logic               cur_pending;
  logic [EVENT_W-1:0] cur_event;
  logic [LEVEL_W-1:0] cur_level;
  logic               cur_match;
  logic               best_take;
  logic               drop_nxt;
  logic               acc_nxt;
  logic               best_ext;

  assign cur_pending = slot_pending_r[idx_r];
  assign cur_event   = slot_event_r[idx_r];
  assign cur_level   = slot_level_r[idx_r];
  assign cur_match   = cur_pending && (cur_event == code_r);
  assign best_take   = (op_r == OP_ACCEPT) && !blk_r && cur_pending &&
                       (cur_level > mask_r) && (cur_level > best_lvl_r);

  assign sts.scan_last = (idx_r == IDX_W'(SLOT_COUNT - 1));

  assign drop_nxt = (op_r == OP_ASSERT) && (code_r != '0) && !hit_r && !free_r;
  assign acc_nxt  = (op_r == OP_ACCEPT) && best_r;
  assign best_ext = (best_event_r >= EXT_EVENT_LOW) && (best_event_r < EXT_EVENT_HIGH);

  always_comb begin
    slot_pending_nxt = slot_pending_r;
    slot_event_nxt   = slot_event_r;
    slot_level_nxt   = slot_level_r;
    if (cmd.step && (op_r == OP_CLEAR) && cur_match) begin
      slot_pending_nxt[idx_r] = 1'b0;
    end
    if (cmd.apply) begin
      case (op_r)
        OP_ASSERT: begin
          if (code_r != '0) begin
            if (hit_r) begin
              slot_level_nxt[hit_idx_r] = lvl_r;
            end else if (free_r) begin
              slot_pending_nxt[free_idx_r] = 1'b1;
              slot_event_nxt[free_idx_r]   = code_r;
              slot_level_nxt[free_idx_r]   = lvl_r;
            end
          end
        end
        OP_ACCEPT: begin
          // external events leave the table once taken
          if (best_r && best_ext) begin
            slot_pending_nxt[best_idx_r] = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_pending_r <= '0;
    end else begin
      slot_pending_r <= slot_pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_event_r <= slot_event_nxt;
    slot_level_r <= slot_level_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(opcode);
      code_r <= event_code;
      lvl_r  <= level;
      mask_r <= interrupt_mask;
      blk_r  <= block_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      best_r     <= 1'b0;
      best_lvl_r <= '0;
    end else if (cmd.load) begin
      idx_r      <= '0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      best_r     <= 1'b0;
      best_lvl_r <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + 1'b1;
      if ((op_r == OP_ASSERT) && cur_match && !hit_r) begin
        hit_r <= 1'b1;
      end
      if ((op_r == OP_ASSERT) && !cur_pending && !free_r) begin
        free_r <= 1'b1;
      end
      // strict compare keeps the lowest slot on equal levels
      if (best_take) begin
        best_r     <= 1'b1;
        best_lvl_r <= cur_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      if ((op_r == OP_ASSERT) && cur_match && !hit_r) begin
        hit_idx_r <= idx_r;
      end
      if ((op_r == OP_ASSERT) && !cur_pending && !free_r) begin
        free_idx_r <= idx_r;
      end
      if (best_take) begin
        best_idx_r   <= idx_r;
        best_event_r <= cur_event;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      accepted_r       <= acc_nxt;
      accepted_event_r <= acc_nxt ? best_event_r : '0;
      accepted_level_r <= acc_nxt ? best_lvl_r : '0;
      dropped_r        <= drop_nxt;
      any_pending_r    <= |slot_pending_nxt;
    end
  end

  assign accepted       = accepted_r;
  assign accepted_event = accepted_event_r;
  assign accepted_level = accepted_level_r;
  assign dropped        = dropped_r;
  assign any_pending    = any_pending_r;

  `IPPT_ASSERT_IMP(a_accept_above_mask, cmd.apply && acc_nxt,
                   (best_lvl_r > mask_r) && !blk_r, "accepted level not above mask")
  `IPPT_ASSERT_NXT(a_assert_leaves_pending,
                   cmd.apply && (op_r == OP_ASSERT) && (code_r != '0) && !drop_nxt,
                   |slot_pending_r, "stored source not pending")

endmodule
`default_nettype wire

@@ src/interrupt_pending_priority_table.sv @@
// channel  dir  payload
// in_ch    in   opcode, event_code, level, interrupt_mask, block_flag
// out_ch   out  accepted, accepted_event, accepted_level, dropped, any_pending
//
// one word passes capture, then the table scan with one slot compared per cycle,
// then a commit that updates the table and loads the result register
// a new word is taken as soon as the scan is back in idle, even if the last result waits
// a stalled result only holds the commit cycle of the next word
// reset (rst_n low, synchronous) empties the table at once
`default_nettype none
module interrupt_pending_priority_table #(
  parameter int SLOT_COUNT = 8
) (
  input wire logic   clk,
  input wire logic   rst_n,
  ippt_in_if.sink    in_ch,
  ippt_out_if.source out_ch
);
  import ippt_pkg::*;

  ippt_cmd_t cmd;
  ippt_sts_t sts;

  ippt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ippt_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .opcode         (in_ch.opcode),
    .event_code     (in_ch.event_code),
    .level          (in_ch.level),
    .interrupt_mask (in_ch.interrupt_mask),
    .block_flag     (in_ch.block_flag),
    .accepted       (out_ch.accepted),
    .accepted_event (out_ch.accepted_event),
    .accepted_level (out_ch.accepted_level),
    .dropped        (out_ch.dropped),
    .any_pending    (out_ch.any_pending)
  );

endmodule
`default_nettype wire
